/* rtl/sdspi_pkg.sv */
// ----------------------------------------------------------------------------
// sdspi_pkg
// Shared types and constants for the SD card SPI controller.
// ----------------------------------------------------------------------------
package sdspi_pkg;

    localparam int BLOCK_BYTES_DEF = 512;
    localparam int WAKE_BYTES_DEF  = 16;

    localparam logic [1:0] KIND_INIT = 2'd0;
    localparam logic [1:0] KIND_READ = 2'd1;
    localparam logic [1:0] KIND_RX   = 2'd2;

    localparam logic [2:0] REG_INIT_RETRIES  = 3'd0;
    localparam logic [2:0] REG_TOKEN_LIMIT   = 3'd1;
    localparam logic [2:0] REG_RESP_POLLS    = 3'd2;
    localparam logic [2:0] REG_SLOW_SPEED    = 3'd3;
    localparam logic [2:0] REG_FAST_SPEED    = 3'd4;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] sector;
        logic [7:0]  rx_byte;
    } sdspi_item_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       tx_valid;
        logic       cs_active;
        logic [6:0] spi_speed;
        logic [7:0] data_byte;
        logic       data_valid;
        logic       data_last;
        logic       done_res;
        logic       success;
        logic       block_addressed;
    } sdspi_result_t;

    typedef struct packed {
        logic [7:0]  init_retries;
        logic [11:0] token_wait_limit;
        logic [3:0]  response_polls;
        logic [6:0]  slow_speed;
        logic [6:0]  fast_speed;
    } sdspi_cfg_t;

endpackage

/* rtl/sdspi_front.sv */
// ----------------------------------------------------------------------------
// sdspi_front
// Input side: registers and configuration, accepts items into a short queue.
// ----------------------------------------------------------------------------
module sdspi_front
    import sdspi_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [11:0] cfg_wdata,
    output sdspi_cfg_t  cfg,
    input  logic        in_valid,
    output logic        in_ready,
    input  sdspi_item_t in_item,
    output logic        q_valid,
    input  logic        q_ready,
    output sdspi_item_t q_item
);
    sdspi_cfg_t  cfg_reg;
    sdspi_item_t buf_reg [2];
    logic        wp_reg, rp_reg;
    logic [1:0]  cnt_reg;

    assign cfg      = cfg_reg;
    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = buf_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.init_retries     <= 8'd255;
            cfg_reg.token_wait_limit <= 12'd2047;
            cfg_reg.response_polls   <= 4'd10;
            cfg_reg.slow_speed       <= 7'd127;
            cfg_reg.fast_speed       <= 7'd0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_INIT_RETRIES: cfg_reg.init_retries     <= cfg_wdata[7:0];
                REG_TOKEN_LIMIT:  cfg_reg.token_wait_limit <= cfg_wdata;
                REG_RESP_POLLS:   cfg_reg.response_polls   <= cfg_wdata[3:0];
                REG_SLOW_SPEED:   cfg_reg.slow_speed       <= cfg_wdata[6:0];
                REG_FAST_SPEED:   cfg_reg.fast_speed       <= cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) buf_reg[wp_reg] <= in_item;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (in_valid && in_ready) wp_reg <= ~wp_reg;
            if (q_valid && q_ready) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, in_valid && in_ready} - {1'b0, q_valid && q_ready};
        end
    end
endmodule

/* rtl/sdspi_engine.sv */
// ----------------------------------------------------------------------------
// sdspi_engine
// Command sequencer: one decision per item, result held in an output register.
// ----------------------------------------------------------------------------
module sdspi_engine
    import sdspi_pkg::*;
#(
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF,
    parameter int WAKE_BYTES  = WAKE_BYTES_DEF
)(
    input  logic          aclk,
    input  logic          aresetn,
    input  sdspi_cfg_t    cfg,
    input  logic          q_valid,
    output logic          q_ready,
    input  sdspi_item_t   q_item,
    output logic          out_valid,
    input  logic          out_ready,
    output sdspi_result_t out_res
);
    localparam int BCW = $clog2(BLOCK_BYTES);
    localparam int WCW = $clog2(WAKE_BYTES + 1);
    localparam int CW  = (BCW > WCW) ? BCW : WCW;

    localparam logic [3:0] PH_IDLE = 4'd0, PH_WAKE = 4'd1, PH_GAP = 4'd2, PH_CMD0 = 4'd3,
        PH_CMD8 = 4'd4, PH_PAD = 4'd5, PH_V2 = 4'd6, PH_CMD58 = 4'd7, PH_PROBE = 4'd8,
        PH_V1 = 4'd9, PH_MMC = 4'd10, PH_FINAL = 4'd11, PH_READ = 4'd12,
        PH_TOKEN = 4'd13, PH_DATA = 4'd14, PH_CRC = 4'd15;
    localparam logic [2:0] S_DELAY = 3'd0, S_RDYD = 3'd1, S_RDYP = 3'd2, S_FRAME = 3'd3,
        S_R1 = 3'd4, S_POST = 3'd5;
    localparam logic [2:0] C0 = 3'd0, C8 = 3'd1, C55 = 3'd2, C41 = 3'd3, C58 = 3'd4,
        C1 = 3'd5, C17 = 3'd6;

    logic [3:0]  phase_reg, phase_next;
    logic [2:0]  sub_reg, sub_next, cmd_reg, cmd_next, fi_reg, fi_next;
    logic [3:0]  poll_reg, poll_next;
    logic [7:0]  retry_reg, retry_next, lr_reg, lr_next;
    logic [11:0] tok_reg, tok_next;
    logic [CW-1:0] bc_reg, bc_next;
    logic [31:0] addr_reg, addr_next;
    logic        bm_reg, bm_next, cs_reg, cs_next;
    logic [6:0]  spd_reg, spd_next;
    logic        ov_reg;
    sdspi_result_t res_reg;

    logic done, ok, dv, dl;
    logic [3:0] npolls;
    logic [7:0] rx;
    logic go;
    logic [7:0] txb_w;

    function automatic logic [2:0] post_len(input logic [2:0] c);
        unique case (c)
            C8:      return 3'd5;
            C41:     return 3'd2;
            C58:     return 3'd6;
            C17:     return 3'd1;
            default: return 3'd0;
        endcase
    endfunction

    function automatic logic [7:0] opcode(input logic [2:0] c);
        unique case (c)
            C0:      return 8'h40;
            C8:      return 8'h48;
            C55:     return 8'h77;
            C41:     return 8'h69;
            C58:     return 8'h7a;
            C1:      return 8'h41;
            default: return 8'h51;
        endcase
    endfunction

    assign go        = q_valid && q_ready;
    assign q_ready   = !ov_reg || out_ready;
    assign out_valid = ov_reg;
    assign out_res   = res_reg;
    assign npolls    = (cfg.response_polls == 4'd0) ? 4'd1 : cfg.response_polls;
    assign rx        = q_item.rx_byte;

    always_comb begin
        logic is_cmd, fin, fok, retry_c, start_c, acmd_c, cdone;
        logic [2:0] rc, sc;
        logic [7:0] r, ar;
        phase_next = phase_reg; sub_next = sub_reg; cmd_next = cmd_reg; fi_next = fi_reg;
        poll_next = poll_reg; retry_next = retry_reg; lr_next = lr_reg; tok_next = tok_reg;
        bc_next = bc_reg; addr_next = addr_reg; bm_next = bm_reg; cs_next = cs_reg;
        spd_next = spd_reg;
        done = 1'b0; ok = 1'b0; dv = 1'b0; dl = 1'b0;
        fin = 1'b0; fok = 1'b0; retry_c = 1'b0; start_c = 1'b0; acmd_c = 1'b0;
        cdone = 1'b0; rc = C0; sc = C0; r = lr_reg; ar = 8'hFF;
        is_cmd = 1'b0;
        if (q_item.kind == KIND_INIT) begin
            spd_next = cfg.slow_speed; bm_next = 1'b0; cs_next = 1'b1;
            bc_next = '0; phase_next = PH_WAKE;
        end else if (q_item.kind == KIND_READ) begin
            addr_next = bm_reg ? q_item.sector : 32'(q_item.sector * 32'(BLOCK_BYTES));
            phase_next = PH_READ; start_c = 1'b1; sc = C17;
        end else if (q_item.kind == KIND_RX && phase_reg != PH_IDLE) begin
            is_cmd = ((phase_reg >= PH_CMD0) && (phase_reg <= PH_MMC) &&
                      (phase_reg != PH_PAD)) || (phase_reg == PH_READ);
            if (is_cmd) begin
                unique case (sub_reg)
                    S_DELAY: begin
                        if (cmd_reg == C55 || cmd_reg == C17) begin
                            if (cmd_reg == C17) cs_next = 1'b1;
                            sub_next = S_FRAME; fi_next = '0;
                        end else sub_next = S_RDYD;
                    end
                    S_RDYD: begin sub_next = S_RDYP; poll_next = npolls; end
                    S_RDYP: begin
                        if (rx == 8'hFF || poll_reg <= 4'd1) begin
                            if (cmd_reg == C17) sub_next = S_DELAY;
                            else begin sub_next = S_FRAME; fi_next = '0; end
                        end else poll_next = poll_reg - 4'd1;
                    end
                    S_FRAME: begin
                        if (fi_reg >= 3'd5) begin sub_next = S_R1; poll_next = npolls; end
                        else fi_next = fi_reg + 3'd1;
                    end
                    S_R1: begin
                        lr_next = rx;
                        if (!rx[7] || poll_reg <= 4'd1) begin
                            if (post_len(cmd_reg) == 3'd0) begin cdone = 1'b1; r = rx; end
                            else begin sub_next = S_POST; fi_next = '0; end
                        end else poll_next = poll_reg - 4'd1;
                    end
                    default: begin
                        if (cmd_reg == C58 && fi_reg == 3'd0)
                            bm_next = (rx[7:6] == 2'b11);
                        fi_next = fi_reg + 3'd1;
                        if (fi_reg + 3'd1 >= post_len(cmd_reg)) cdone = 1'b1;
                    end
                endcase
                if (cdone) begin
                    unique case (phase_reg)
                        PH_CMD0: begin
                            if (r == 8'd1) begin phase_next = PH_CMD8; start_c = 1'b1; sc = C8; end
                            else begin retry_c = 1'b1; rc = C0; end
                        end
                        PH_CMD8: begin
                            if (r == 8'd1) phase_next = PH_PAD;
                            else begin phase_next = PH_PROBE; start_c = 1'b1; sc = C55; end
                        end
                        PH_V2, PH_PROBE, PH_V1: begin
                            if (cmd_reg == C55) begin
                                if (r > 8'd1) begin lr_next = 8'hFF; acmd_c = 1'b1; ar = 8'hFF; end
                                else begin start_c = 1'b1; sc = C41; end
                            end else begin acmd_c = 1'b1; ar = r; end
                        end
                        PH_MMC: begin
                            if (r == 8'd0) phase_next = PH_FINAL;
                            else begin retry_c = 1'b1; rc = C1; end
                        end
                        PH_CMD58: begin
                            if (r != 8'd0) fin = 1'b1; else phase_next = PH_FINAL;
                        end
                        default: begin
                            if (r[7]) fin = 1'b1;
                            else begin phase_next = PH_TOKEN; tok_next = cfg.token_wait_limit; end
                        end
                    endcase
                    if (acmd_c) begin
                        if (phase_reg == PH_V2) begin
                            if (!ar[0]) begin phase_next = PH_CMD58; start_c = 1'b1; sc = C58; end
                            else begin retry_c = 1'b1; rc = C55; end
                        end else if (phase_reg == PH_PROBE) begin
                            retry_next = cfg.init_retries;
                            if (ar <= 8'd1) begin phase_next = PH_V1; start_c = 1'b1; sc = C55; end
                            else begin phase_next = PH_MMC; start_c = 1'b1; sc = C1; end
                        end else begin
                            if (!ar[0]) phase_next = PH_FINAL;
                            else begin retry_c = 1'b1; rc = C55; end
                        end
                    end
                end
            end else begin
                unique case (phase_reg)
                    PH_WAKE: begin
                        bc_next = bc_reg + 1'b1;
                        if (bc_reg + 1'b1 >= CW'(WAKE_BYTES)) begin
                            phase_next = PH_GAP; cs_next = 1'b0; bc_next = '0;
                        end
                    end
                    PH_GAP: begin
                        bc_next = bc_reg + 1'b1;
                        if (bc_reg + 1'b1 >= CW'(2)) begin
                            cs_next = 1'b1; retry_next = cfg.init_retries;
                            phase_next = PH_CMD0; start_c = 1'b1; sc = C0;
                        end
                    end
                    PH_PAD: begin
                        retry_next = cfg.init_retries; phase_next = PH_V2;
                        start_c = 1'b1; sc = C55;
                    end
                    PH_FINAL: begin spd_next = cfg.fast_speed; fin = 1'b1; fok = 1'b1; end
                    PH_TOKEN: begin
                        if (rx == 8'hFE) begin phase_next = PH_DATA; bc_next = '0; end
                        else if (tok_reg == 12'd0) fin = 1'b1;
                        else tok_next = tok_reg - 12'd1;
                    end
                    PH_DATA: begin
                        dv = 1'b1;
                        if (bc_reg[BCW-1:0] == BCW'(BLOCK_BYTES - 1)) begin
                            dl = 1'b1; phase_next = PH_CRC; bc_next = '0;
                        end else bc_next = bc_reg + 1'b1;
                    end
                    default: begin
                        bc_next = bc_reg + 1'b1;
                        if (bc_reg + 1'b1 >= CW'(2)) begin fin = 1'b1; fok = 1'b1; end
                    end
                endcase
            end
        end
        if (retry_c) begin
            if (retry_reg == 8'd0) fin = 1'b1;
            else begin retry_next = retry_reg - 8'd1; start_c = 1'b1; sc = rc; end
        end
        if (start_c && !fin) begin
            cmd_next = sc; fi_next = '0;
            sub_next = (sc == C41 || sc == C17) ? S_RDYD : S_DELAY;
        end
        if (fin) begin
            phase_next = PH_IDLE; cs_next = 1'b0; done = 1'b1; ok = fok;
        end
    end

    always_comb begin
        txb_w = 8'h00;
        if (phase_next != PH_IDLE) begin
            if ((((phase_next >= PH_CMD0) && (phase_next <= PH_MMC) &&
                  (phase_next != PH_PAD)) || (phase_next == PH_READ)) &&
                sub_next == S_FRAME) begin
                if (fi_next == 3'd0) txb_w = opcode(cmd_next);
                else if (fi_next >= 3'd5)
                    txb_w = (cmd_next == C0) ? 8'h95 : ((cmd_next == C8) ? 8'h87 : 8'hFF);
                else if (cmd_next == C8)
                    txb_w = (fi_next == 3'd3) ? 8'h01 : ((fi_next == 3'd4) ? 8'hAA : 8'h00);
                else if (cmd_next == C41)
                    txb_w = (fi_next == 3'd1 && phase_next == PH_V2) ? 8'h40 : 8'h00;
                else if (cmd_next == C17)
                    txb_w = addr_next[8*(3'd4 - fi_next) +: 8];
            end else txb_w = 8'hFF;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE; sub_reg <= S_DELAY; cmd_reg <= C0; fi_reg <= '0;
            poll_reg <= '0; retry_reg <= '0; lr_reg <= 8'hFF; tok_reg <= '0;
            bc_reg <= '0; addr_reg <= '0; bm_reg <= 1'b0; cs_reg <= 1'b0;
            spd_reg <= 7'd127; ov_reg <= 1'b0;
        end else begin
            if (go) begin
                phase_reg <= phase_next; sub_reg <= sub_next; cmd_reg <= cmd_next;
                fi_reg <= fi_next; poll_reg <= poll_next; retry_reg <= retry_next;
                lr_reg <= lr_next; tok_reg <= tok_next; bc_reg <= bc_next;
                addr_reg <= addr_next; bm_reg <= bm_next; cs_reg <= cs_next;
                spd_reg <= spd_next;
                ov_reg <= 1'b1;
            end else if (out_ready) ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (go) begin
            res_reg.tx_byte         <= txb_w;
            res_reg.tx_valid        <= (phase_next != PH_IDLE);
            res_reg.cs_active       <= cs_next;
            res_reg.spi_speed       <= spd_next;
            res_reg.data_byte       <= dv ? rx : 8'h00;
            res_reg.data_valid      <= dv;
            res_reg.data_last       <= dl;
            res_reg.done_res        <= done;
            res_reg.success         <= done && ok;
            res_reg.block_addressed <= bm_next;
        end
    end
endmodule

/* rtl/sd_spi_init_and_block_read.sv */
// ----------------------------------------------------------------------------
// sd_spi_init_and_block_read
// SD card SPI-mode init and single-block read controller.
// ----------------------------------------------------------------------------
// Each accepted item (init request, read request or received byte) yields
// exactly one result item. Items pass a two-entry queue into a sequencer that
// decides combinationally, so one item per clock is sustained while m_tready
// holds; an item is registered in the queue, then its result in the result register.
module sd_spi_init_and_block_read
    import sdspi_pkg::*;
#(
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF,
    parameter int WAKE_BYTES  = WAKE_BYTES_DEF
)(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [11:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // sector[31:0], rx_byte[39:32]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // tx_byte, tx_valid, cs_active, spi_speed, data_byte, 0
    output logic        m_tlast,   // data_last
    output logic [3:0]  m_tuser    // data_valid, done_res, success, block_addressed
);
    sdspi_cfg_t    cfg;
    sdspi_item_t   in_item, q_item;
    sdspi_result_t res;
    logic          q_valid, q_ready;

    assign in_item.kind    = s_tuser;
    assign in_item.sector  = s_tdata[31:0];
    assign in_item.rx_byte = s_tdata[39:32];

    sdspi_front u_front (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata), .cfg(cfg), .in_valid(s_tvalid), .in_ready(s_tready),
        .in_item(in_item), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
    );

    sdspi_engine #(.BLOCK_BYTES(BLOCK_BYTES), .WAKE_BYTES(WAKE_BYTES)) u_engine (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg), .q_valid(q_valid), .q_ready(q_ready),
        .q_item(q_item), .out_valid(m_tvalid), .out_ready(m_tready), .out_res(res)
    );

    assign m_tdata = {7'd0, res.data_byte, res.spi_speed, res.cs_active,
                      res.tx_valid, res.tx_byte};
    assign m_tlast = res.data_last;
    assign m_tuser = {res.block_addressed, res.success, res.done_res, res.data_valid};
endmodule

/* rtl/sdspi_checker.sv */
// ----------------------------------------------------------------------------
// sdspi_checker
// Port-level checks for the SD SPI controller.
// ----------------------------------------------------------------------------
module sdspi_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast,
    input logic [3:0]  m_tuser
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser[0])
        else $error("last without data");
    a_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2] |-> m_tuser[1])
        else $error("success without done");
    a_txb: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[8] |-> m_tdata[7:0] == 8'h00)
        else $error("tx byte without tx valid");
endmodule

bind sd_spi_init_and_block_read sdspi_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .m_tlast(m_tlast), .m_tuser(m_tuser)
);
